@@ sv/hrlp_pkg.sv @@
// Shared types, constants and the nibble decoder of the hex record line parser.
`default_nettype none

package hrlp_pkg;

	// Longest line, in characters, before an overflow error.
	localparam int LINE_LIMIT = 255;
	// Shortest line that carries a complete record.
	localparam int MIN_LINE   = 18;
	// Width of the character counter: holds 0 .. LINE_LIMIT.
	localparam int CNT_W      = $clog2(LINE_LIMIT + 1);

	// Character positions of the address and data nibbles.
	localparam int ADDR_FIRST = 1;
	localparam int ADDR_LAST  = 8;
	localparam int DATA_FIRST = 10;
	localparam int DATA_LAST  = 17;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SEMI    = 8'h3B;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_WRITE    = 2'd0;
	localparam kind_t KIND_OVERFLOW = 2'd1;
	localparam kind_t KIND_SHORT    = 2'd2;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] address;
		logic [31:0] word;
		logic        over;
	} result_t;

	// Hex digit of either case to its value; any other byte reads as zero.
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [3:0] n;
		n = 4'd0;
		case (c) inside
			[8'h30:8'h39]: n = c[3:0];
			[8'h41:8'h46],
			[8'h61:8'h66]: n = c[3:0] + 4'd9;
			default:       n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ sv/hex_record_line_parser_core.sv @@
// Top level of the hex record line parser: line assembly, error detection and output buffer.
`default_nettype none

// Takes one received character per request on the rx channel and sends at most
// one result per character on the res channel. A newline or semicolon ends a
// line: a line of at least 18 characters yields a write request carrying the
// address from characters 1 to 8 and the data word from characters 10 to 17; a
// shorter one yields an insufficient-data error. Any other character arriving
// when the line already holds the limit yields an overflow error. A semicolon,
// or any error, sets session_over and the block then drops every character
// until reset. Rate: one character per clock while rx_stall is low. The line
// state is held in a single register stage; a result is formed from it and the
// character taken and registered into the output buffer, whose two entries let
// characters keep flowing while the consumer stalls; rx_stall rises only once
// both entries are full.
module hex_record_line_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// character channel
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [1:0]       result_kind,
	output logic [31:0]      write_address,
	output logic [31:0]      write_word,
	output logic             session_over
);

	// Line state.
	hrlp_pkg::count_t  count_q;
	logic [31:0]       addr_q;
	logic [31:0]       data_q;
	logic              stopped_q;

	// Output buffer: head register drives the ports, skid entry catches overflow.
	logic              head_valid_q;
	hrlp_pkg::result_t head_q;
	logic              skid_valid_q;
	hrlp_pkg::result_t skid_q;

	logic              take;
	logic              pop;
	logic              is_term;
	logic              is_semi;
	logic              long_enough;
	logic              at_limit;
	logic              has_result;
	logic              in_addr;
	logic              in_data;
	logic [3:0]        nib;
	hrlp_pkg::result_t res_new;

	// Hold the input only when both buffer entries are occupied.
	assign rx_stall = skid_valid_q;
	assign take     = rx_valid && !rx_stall;
	assign pop      = head_valid_q && !res_stall;

	assign is_semi     = (rx_byte == hrlp_pkg::CHAR_SEMI);
	assign is_term     = is_semi || (rx_byte == hrlp_pkg::CHAR_NEWLINE);
	assign long_enough = (count_q >= hrlp_pkg::CNT_W'(hrlp_pkg::MIN_LINE));
	assign at_limit    = (count_q >= hrlp_pkg::CNT_W'(hrlp_pkg::LINE_LIMIT));
	assign in_addr     = (count_q >= hrlp_pkg::CNT_W'(hrlp_pkg::ADDR_FIRST)) &&
	                     (count_q <= hrlp_pkg::CNT_W'(hrlp_pkg::ADDR_LAST));
	assign in_data     = (count_q >= hrlp_pkg::CNT_W'(hrlp_pkg::DATA_FIRST)) &&
	                     (count_q <= hrlp_pkg::CNT_W'(hrlp_pkg::DATA_LAST));
	assign nib         = hrlp_pkg::nibble_of(rx_byte);

	// A result arises on a line end or on a character past the limit.
	assign has_result = take && !stopped_q && (is_term || at_limit);

	always_comb begin
		res_new.kind    = hrlp_pkg::KIND_OVERFLOW;
		res_new.address = 32'd0;
		res_new.word    = 32'd0;
		res_new.over    = 1'b1;
		if (is_term) begin
			if (long_enough) begin
				res_new.kind    = hrlp_pkg::KIND_WRITE;
				res_new.address = addr_q;
				res_new.word    = data_q;
				res_new.over    = is_semi;
			end else begin
				res_new.kind = hrlp_pkg::KIND_SHORT;
			end
		end
	end

	// Line state: advance on ordinary characters, clear on a good line end,
	// freeze on an error or a closing semicolon.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			addr_q    <= '0;
			data_q    <= '0;
			stopped_q <= 1'b0;
		end else if (take && !stopped_q) begin
			if (is_term) begin
				if (long_enough) begin
					count_q <= '0;
					addr_q  <= '0;
					data_q  <= '0;
					if (is_semi) begin
						stopped_q <= 1'b1;
					end
				end else begin
					stopped_q <= 1'b1;
				end
			end else if (at_limit) begin
				stopped_q <= 1'b1;
			end else begin
				count_q <= count_q + hrlp_pkg::CNT_W'(1);
				if (in_addr) begin
					addr_q <= {addr_q[27:0], nib};
				end else if (in_data) begin
					data_q <= {data_q[27:0], nib};
				end
			end
		end
	end

	// Output buffer valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				head_valid_q <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
			if (has_result) begin
				if (!head_valid_q || pop) begin
					head_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	// Output buffer payload: refill the head from the skid entry on a pop,
	// otherwise drop a new result into whichever entry is free.
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			head_q <= skid_q;
		end else if (has_result && (!head_valid_q || pop)) begin
			head_q <= res_new;
		end
		if (has_result && head_valid_q && !pop) begin
			skid_q <= res_new;
		end
	end

	assign res_valid     = head_valid_q;
	assign result_kind   = head_q.kind;
	assign write_address = head_q.address;
	assign write_word    = head_q.word;
	assign session_over  = head_q.over;

endmodule

`default_nettype wire
